// ----- hw/rtl/sswd_pkg.sv -----
// Shared types, constants, microcode encoding and coil helpers for the wave-drive sequencer.
`default_nettype none

package sswd_pkg;

    // Default values of the top-level parameters.
    localparam int CYCLES_PER_FRAME_DEF = 20;
    localparam int MAX_COMMAND_DEF      = 100;
    localparam int MOTOR_COUNT_DEF      = 6;

    // Fixed widths of the datapath.
    localparam int MOTOR_SLOTS = 6;
    localparam int SPEED_W     = 8;
    localparam int CYC_W       = 5;
    localparam int MOTOR_W     = 3;
    localparam int PINS_W      = 12;
    localparam int PROD_W      = 12;
    localparam int QUOT_W      = 5;
    localparam int UPC_W       = 4;
    localparam int IN_DATA_W   = MOTOR_SLOTS * SPEED_W;
    localparam int OUT_DATA_W  = 16;

    // Scaled reciprocal of the period divisor; the shift keeps every product exact.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int MUL_W       = PROD_W + RECIP_W;

    localparam logic [MOTOR_W-1:0] NO_MOTOR = 3'd6;

    // Datapath operation carried by each microcode word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INIT,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_WALK,
        OP_EMIT
    } t_op;

    // Jump condition carried by each microcode word.
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_BEAT,
        CND_IS_LOAD,
        CND_FRAME_RUN,
        CND_MORE_MOTORS,
        CND_WALK_BUSY,
        CND_OUT_FULL
    } t_cond;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Status flags that the datapath reports to the sequencer.
    typedef struct packed {
        logic no_beat;
        logic is_load;
        logic frame_run;
        logic more_motors;
        logic walk_busy;
        logic out_full;
    } t_status;

    // Microcode addresses.
    localparam t_upc UA_WAIT      = 4'd0;
    localparam t_upc UA_KIND      = 4'd1;
    localparam t_upc UA_FRAME     = 4'd2;
    localparam t_upc UA_INIT      = 4'd3;
    localparam t_upc UA_DIV_LOAD  = 4'd4;
    localparam t_upc UA_DIV_STEP  = 4'd5;
    localparam t_upc UA_DIV_STORE = 4'd6;
    localparam t_upc UA_WALK      = 4'd7;
    localparam t_upc UA_EMIT      = 4'd8;
    localparam t_upc UA_RETURN    = 4'd9;

    // Pin numbers of each motor's four coils; motors 3..5 share pins with 0..2.
    typedef logic [3:0] t_coil_row [4];
    localparam t_coil_row COIL_MAP [MOTOR_SLOTS] = '{
        '{4'd0, 4'd1, 4'd2,  4'd3},
        '{4'd4, 4'd5, 4'd6,  4'd7},
        '{4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd1, 4'd0, 4'd3,  4'd2},
        '{4'd5, 4'd4, 4'd7,  4'd6},
        '{4'd9, 4'd8, 4'd11, 4'd10}
    };

    // Drive one motor's coils: the hot coil high and the other three low, or all four low without hot_en.
    function automatic logic [PINS_W-1:0] drive_coils(
        input logic [PINS_W-1:0]  pins,
        input logic [MOTOR_W-1:0] motor,
        input logic               hot_en,
        input logic [1:0]         hot
    );
        logic [PINS_W-1:0] res;
        res = pins;
        for (int j = 0; j < 4; j++) begin
            res[COIL_MAP[motor][j]] = hot_en && (hot == 2'(j));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sswd_ucode_rom.sv -----
// Read-only control store holding the sequencer's program.
`default_nettype none

module sswd_ucode_rom
    import sswd_pkg::*;
(
    input  wire t_upc   i_addr,
    output t_uword      o_word
);

    // One control word per step: operation, jump condition, jump target.
    always_comb begin
        case (i_addr)
            UA_WAIT:      o_word = '{OP_ACCEPT,    CND_NO_BEAT,     UA_WAIT};
            UA_KIND:      o_word = '{OP_NOP,       CND_IS_LOAD,     UA_EMIT};
            UA_FRAME:     o_word = '{OP_NOP,       CND_FRAME_RUN,   UA_WALK};
            UA_INIT:      o_word = '{OP_INIT,      CND_NEVER,       UA_WAIT};
            UA_DIV_LOAD:  o_word = '{OP_DIV_LOAD,  CND_NEVER,       UA_WAIT};
            UA_DIV_STEP:  o_word = '{OP_DIV_STEP,  CND_NEVER,       UA_WAIT};
            UA_DIV_STORE: o_word = '{OP_DIV_STORE, CND_MORE_MOTORS, UA_DIV_LOAD};
            UA_WALK:      o_word = '{OP_WALK,      CND_WALK_BUSY,   UA_WALK};
            UA_EMIT:      o_word = '{OP_EMIT,      CND_OUT_FULL,    UA_EMIT};
            UA_RETURN:    o_word = '{OP_NOP,       CND_ALWAYS,      UA_WAIT};
            default:      o_word = '{OP_NOP,       CND_ALWAYS,      UA_WAIT};
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sswd_sequencer.sv -----
// Step counter with conditional jumps that walks the microcode program.
`default_nettype none

module sswd_sequencer
    import sswd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_status i_status,
    output t_uword       o_uword
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_word;
    logic   w_jump;

    sswd_ucode_rom u_rom (
        .i_addr (r_upc),
        .o_word (w_word)
    );

    // Select the jump condition named by the current word.
    always_comb begin
        case (w_word.cond)
            CND_NEVER:       w_jump = 1'b0;
            CND_ALWAYS:      w_jump = 1'b1;
            CND_NO_BEAT:     w_jump = i_status.no_beat;
            CND_IS_LOAD:     w_jump = i_status.is_load;
            CND_FRAME_RUN:   w_jump = i_status.frame_run;
            CND_MORE_MOTORS: w_jump = i_status.more_motors;
            CND_WALK_BUSY:   w_jump = i_status.walk_busy;
            CND_OUT_FULL:    w_jump = i_status.out_full;
            default:         w_jump = 1'b0;
        endcase
        n_upc   = w_jump ? w_word.target : r_upc + t_upc'(1);
        o_uword = w_word;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sswd_datapath.sv -----
// Registers, period divider, schedule walk and output register under microcode control.
`default_nettype none

module sswd_datapath
    import sswd_pkg::*;
#(
    parameter int CYCLES_PER_FRAME = CYCLES_PER_FRAME_DEF,
    parameter int MAX_COMMAND      = MAX_COMMAND_DEF,
    parameter int MOTOR_COUNT      = MOTOR_COUNT_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire t_uword           i_uword,
    output t_status               o_status,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire [IN_DATA_W-1:0]   i_s_tdata,
    input  wire [0:0]             i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam logic [CYC_W-1:0]   CYC_LAST  = CYC_W'(CYCLES_PER_FRAME);
    localparam logic [MOTOR_W-1:0] MOT_END   = MOTOR_W'(MOTOR_COUNT);
    localparam logic [MOTOR_W-1:0] MOT_LAST  = MOTOR_W'(MOTOR_COUNT - 1);
    localparam logic [SPEED_W-1:0] CMD_MAX   = SPEED_W'(MAX_COMMAND);
    localparam logic [PROD_W-1:0]  CYC_SPAN  = PROD_W'(CYCLES_PER_FRAME - 1);
    // Rounded-up reciprocal of MAX_COMMAND-1, scaled by 2**RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'(((1 << RECIP_SHIFT) + MAX_COMMAND - 2) / (MAX_COMMAND - 1));

    // Architectural state.
    logic [SPEED_W-1:0] r_pending [MOTOR_SLOTS];
    logic [SPEED_W-1:0] n_pending [MOTOR_SLOTS];
    logic [QUOT_W-1:0]  r_per_mag [MOTOR_SLOTS];
    logic [QUOT_W-1:0]  n_per_mag [MOTOR_SLOTS];
    logic               r_per_neg [MOTOR_SLOTS];
    logic               n_per_neg [MOTOR_SLOTS];
    // Running value of cycle modulo period, one per motor.
    logic [QUOT_W-1:0]  r_rem [MOTOR_SLOTS];
    logic [QUOT_W-1:0]  n_rem [MOTOR_SLOTS];
    logic [CYC_W-1:0]   r_cyc, n_cyc;
    logic [MOTOR_W-1:0] r_m, n_m;
    logic [1:0]         r_phase, n_phase;
    logic [PINS_W-1:0]  r_pins, n_pins;

    // Working registers.
    logic               r_is_load, n_is_load;
    logic [MOTOR_W-1:0] r_active, n_active;
    logic [MOTOR_W-1:0] r_k, n_k;
    logic [PROD_W-1:0]  r_div_rem, n_div_rem;
    logic [QUOT_W-1:0]  r_quot, n_quot;
    logic               r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // Combinational helpers.
    logic [SPEED_W-1:0] w_cmd;
    logic [SPEED_W-1:0] w_abs;
    logic [SPEED_W-1:0] w_sat;
    logic [PROD_W-1:0]  w_prod;
    logic [MUL_W-1:0]   w_mul;
    logic [QUOT_W-1:0]  w_quot;
    logic               w_m_in;
    logic [QUOT_W-1:0]  w_cur_mag;
    logic               w_cur_neg;
    logic [QUOT_W-1:0]  w_cur_rem;
    logic               w_walk_done;
    logic               w_out_full;
    logic [1:0]         w_hot;

    // Period arithmetic on the command selected by the motor counter.
    always_comb begin
        w_cmd  = r_pending[r_k];
        w_abs  = w_cmd[SPEED_W-1] ? (~w_cmd + SPEED_W'(1)) : w_cmd;
        w_sat  = (w_abs > CMD_MAX) ? CMD_MAX : w_abs;
        w_prod = CYC_SPAN * PROD_W'(CMD_MAX - w_sat);
        // The quotient by MAX_COMMAND-1 sits above the scaling shift of the product.
        w_mul  = MUL_W'(r_div_rem) * MUL_W'(RECIP);
        w_quot = w_mul[RECIP_SHIFT +: QUOT_W];
    end

    // Schedule position under the walk cursor.
    always_comb begin
        w_m_in      = r_m < MOT_END;
        w_cur_mag   = w_m_in ? r_per_mag[r_m] : '0;
        w_cur_neg   = w_m_in ? r_per_neg[r_m] : 1'b0;
        w_cur_rem   = w_m_in ? r_rem[r_m] : '0;
        w_walk_done = (!w_m_in && (r_cyc == CYC_LAST))
                   || (w_m_in && (w_cur_mag != '0) && (w_cur_rem == '0));
        w_out_full  = r_ovalid && !i_m_tready;
        w_hot       = w_cur_neg ? (2'd3 - r_phase) : r_phase;
    end

    // Next state for the operation named by the control word.
    always_comb begin
        n_pending = r_pending;
        n_per_mag = r_per_mag;
        n_per_neg = r_per_neg;
        n_rem     = r_rem;
        n_cyc     = r_cyc;
        n_m       = r_m;
        n_phase   = r_phase;
        n_pins    = r_pins;
        n_is_load = r_is_load;
        n_active  = r_active;
        n_k       = r_k;
        n_div_rem = r_div_rem;
        n_quot    = r_quot;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_odata   = r_odata;

        case (i_uword.op)
            OP_ACCEPT: begin
                if (i_s_tvalid) begin
                    n_is_load = ~i_s_tuser[0];
                    n_active  = NO_MOTOR;
                    if (!i_s_tuser[0]) begin
                        for (int i = 0; i < MOTOR_SLOTS; i++) begin
                            n_pending[i] = i_s_tdata[SPEED_W*i +: SPEED_W];
                        end
                    end
                end
            end
            OP_INIT: begin
                n_cyc   = CYC_W'(1);
                n_m     = '0;
                n_phase = '0;
                n_k     = '0;
            end
            OP_DIV_LOAD: begin
                n_div_rem = w_prod;
            end
            OP_DIV_STEP: begin
                // Whole quotient in one step by the scaled reciprocal.
                n_quot = w_quot;
            end
            OP_DIV_STORE: begin
                n_per_mag[r_k] = (w_cmd == '0) ? '0 : r_quot + QUOT_W'(1);
                n_per_neg[r_k] = w_cmd[SPEED_W-1];
                // First cycle of a frame is 1: its remainder is 0 only for period 1.
                n_rem[r_k]     = (r_quot == '0) ? '0 : QUOT_W'(1);
                n_k            = r_k + MOTOR_W'(1);
            end
            OP_WALK: begin
                if (!w_m_in) begin
                    n_m     = '0;
                    n_phase = '0;
                    if (r_cyc == CYC_LAST) begin
                        n_cyc = '0;
                    end else begin
                        n_cyc = r_cyc + CYC_W'(1);
                        for (int i = 0; i < MOTOR_SLOTS; i++) begin
                            n_rem[i] = ({1'b0, r_rem[i]} + 6'd1 == {1'b0, r_per_mag[i]})
                                     ? '0 : r_rem[i] + QUOT_W'(1);
                        end
                    end
                end else if (w_cur_mag == '0) begin
                    n_pins = drive_coils(r_pins, r_m, 1'b0, 2'd0);
                    n_m    = r_m + MOTOR_W'(1);
                end else if (w_cur_rem == '0) begin
                    n_pins   = drive_coils(r_pins, r_m, 1'b1, w_hot);
                    n_active = r_m;
                    n_phase  = r_phase + 2'd1;
                    if (r_phase == 2'd3) begin
                        n_m = r_m + MOTOR_W'(1);
                    end
                end else begin
                    n_m = r_m + MOTOR_W'(1);
                end
            end
            OP_EMIT: begin
                if (!w_out_full) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_active, r_pins};
                end
            end
            default: begin
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_SLOTS; i++) begin
                r_pending[i] <= '0;
                r_per_mag[i] <= '0;
                r_per_neg[i] <= 1'b0;
                r_rem[i]     <= '0;
            end
            r_cyc     <= '0;
            r_m       <= '0;
            r_phase   <= '0;
            r_pins    <= '0;
            r_is_load <= 1'b0;
            r_active  <= NO_MOTOR;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_per_mag <= n_per_mag;
            r_per_neg <= n_per_neg;
            r_rem     <= n_rem;
            r_cyc     <= n_cyc;
            r_m       <= n_m;
            r_phase   <= n_phase;
            r_pins    <= n_pins;
            r_is_load <= n_is_load;
            r_active  <= n_active;
            r_k       <= n_k;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_div_rem <= n_div_rem;
        r_quot    <= n_quot;
        r_odata   <= n_odata;
    end

    // Status back to the sequencer, and the stream ports.
    always_comb begin
        o_status.no_beat     = !i_s_tvalid;
        o_status.is_load     = r_is_load;
        o_status.frame_run   = r_cyc != '0;
        o_status.more_motors = r_k != MOT_LAST;
        o_status.walk_busy   = !w_walk_done;
        o_status.out_full    = w_out_full;
        o_s_tready           = i_uword.op == OP_ACCEPT;
        o_m_tvalid           = r_ovalid;
        o_m_tdata            = r_odata;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/six_stepper_wave_drive_sequencer.sv -----
// Top level of the six-motor stepper wave-drive sequencer.
//
//  Channel  Direction  Contents
//  s_*      in         tuser[0] cmd (0 load speeds, 1 tick); tdata speed_m0..speed_m5
//  m_*      out        tdata coil_pins, active_motor
//
// A load beat goes through the kind step to the emit step, which registers its result
// once the output register is free. A tick beat walks the schedule one position (one
// motor, or one cycle wrap) per clock until a motor fires or the frame ends; at a
// frame start it first runs an init step and the period arithmetic (product,
// reciprocal, store per motor). One beat is worked at a time; the input is ready
// again after the return step that follows the emit, and a new beat is taken while
// the last result waits. Reset is synchronous and active low and clears all state
// but the divider and output payload registers, with no clearing pass.
`default_nettype none

module six_stepper_wave_drive_sequencer
    import sswd_pkg::*;
#(
    parameter int CYCLES_PER_FRAME = CYCLES_PER_FRAME_DEF,
    parameter int MAX_COMMAND      = MAX_COMMAND_DEF,
    parameter int MOTOR_COUNT      = MOTOR_COUNT_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire [IN_DATA_W-1:0]   i_s_tdata,   // speed_m0 [7:0] .. speed_m5 [47:40]
    input  wire [0:0]             i_s_tuser,   // cmd [0]
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // coil_pins [11:0], active_motor [14:12]
);

    t_uword  w_uword;
    t_status w_status;

    sswd_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    sswd_datapath #(
        .CYCLES_PER_FRAME (CYCLES_PER_FRAME),
        .MAX_COMMAND      (MAX_COMMAND),
        .MOTOR_COUNT      (MOTOR_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uword    (w_uword),
        .o_status   (w_status),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sswd_checker.sv -----
// Port-level checks for the wave-drive sequencer, bound to the top level.
`default_nettype none

module sswd_checker
    import sswd_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_tvalid,
    input wire                  o_s_tready,
    input wire [0:0]            i_s_tuser,
    input wire                  o_m_tvalid,
    input wire                  i_m_tready,
    input wire [OUT_DATA_W-1:0] o_m_tdata
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result data changed while stalled");

    // Only one beat is worked at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a beat is in work");

    // A load beat accepted with an empty output returns a result with no motor.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser[0] && !o_m_tvalid)
        |-> ##3 (o_m_tvalid && (o_m_tdata[14:12] == NO_MOTOR)))
        else $error("load result missing or names a motor");

endmodule

bind six_stepper_wave_drive_sequencer sswd_checker u_sswd_checker (.*);

`default_nettype wire

// ----- tb/tb_six_stepper_wave_drive_sequencer.sv -----
// Self-checking stream testbench for the six-motor stepper wave-drive sequencer.

module tb_six_stepper_wave_drive_sequencer;
    import sswd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Item kinds carried in tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Hot coil index meaning all four coils low.
    localparam int NO_HOT = -1;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_OFF_ITEM  = 500;
    localparam int DRAIN_ITEM     = 1000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int SETTLE_CYCLES  = 256;

    // One output beat: coil pins in the low bits, motor index above them.
    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [PINS_W-1:0]  pins;
    } t_coil_beat;

    // One row of the directed table; when given is set, the typed beat is expected.
    typedef struct packed {
        logic                 cmd;
        logic [IN_DATA_W-1:0] speeds;
        logic                 given;
        logic [PINS_W-1:0]    pins;
        logic [MOTOR_W-1:0]   motor;
    } t_stim_row;

    localparam int N_DIRECTED = 20;

    // Speeds are packed {m5, m4, m3, m2, m1, m0}.
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // All motors stopped after reset: the frame ends with no motor firing.
        '{CMD_TICK, 48'h0, 1'b1, 12'h000, NO_MOTOR},
        // Extremes: -128 saturates, 127 saturates, +/-1 give the slowest period.
        '{CMD_LOAD, {8'h00, 8'hFF, 8'h01, 8'h00, 8'h7F, 8'h80}, 1'b1, 12'h000, NO_MOTOR},
        // Motor 0 runs in reverse at period 1: first phase drives pin 3.
        '{CMD_TICK, 48'h0, 1'b1, 12'h008, 3'd0},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        // New speeds stay pending until the running frame ends.
        '{CMD_LOAD, {8'h01, 8'hFF, 8'h7F, 8'h80, 8'h64, 8'h9C}, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_LOAD, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR},
        '{CMD_TICK, 48'h0, 1'b0, 12'h000, NO_MOTOR}
    };

    // Clock, reset and stream signals; the ones driven here are known from time zero.
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Scoreboard and pacing state.
    t_coil_beat due_beats [$];
    t_coil_beat oldest_due;
    int         mismatches = 0;
    int         burst_left = 0;
    bit         hold_req   = 1'b0;
    int         rx_count   = 0;
    int         rx_mode    = 0;

    // Predicted sequencer state.
    logic signed [SPEED_W-1:0] held_speed [MOTOR_SLOTS] = '{default: '0};
    int                        run_period [MOTOR_SLOTS] = '{default: 0};
    int                        frame_cycle = 0;
    int                        next_motor  = 0;
    int                        next_phase  = 0;
    logic [PINS_W-1:0]         coil_state  = '0;

    six_stepper_wave_drive_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // speed_m0 [7:0] .. speed_m5 [47:40]
        .i_s_tuser  (s_tuser),    // cmd [0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)     // coil_pins [11:0], active_motor [14:12]
    );

    always #4 i_clk = ~i_clk;

    // Signed step period of one speed command; zero means the motor is stopped.
    function automatic int speed_to_period(input logic signed [SPEED_W-1:0] sp);
        int mag;
        int per;
        mag = (sp < 0) ? -int'(sp) : int'(sp);
        if (mag == 0)
            return 0;
        if (mag > MAX_COMMAND_DEF)
            mag = MAX_COMMAND_DEF;
        per = (CYCLES_PER_FRAME_DEF - 1) * (MAX_COMMAND_DEF - mag) / (MAX_COMMAND_DEF - 1) + 1;
        return (sp < 0) ? -per : per;
    endfunction

    // Set one motor's four coils: only the hot one high.
    function automatic void set_coils(input int m, input int hot);
        for (int j = 0; j < 4; j++) begin
            coil_state[COIL_MAP[m][j]] = (j == hot);
        end
    endfunction

    // Advance the predicted schedule by one item and return the beat it causes.
    function automatic t_coil_beat next_pin_beat(
        input logic                 cmd,
        input logic [IN_DATA_W-1:0] speeds
    );
        int         cyc;
        int         m;
        int         per;
        int         mag;
        int         hot;
        t_coil_beat beat;
        beat.motor = NO_MOTOR;
        if (cmd == CMD_LOAD) begin
            for (int i = 0; i < MOTOR_SLOTS; i++)
                held_speed[i] = speeds[SPEED_W*i +: SPEED_W];
        end else begin
            cyc = frame_cycle;
            m   = next_motor;
            // A new frame latches the pending speeds as periods.
            if (cyc == 0) begin
                for (int i = 0; i < MOTOR_SLOTS; i++)
                    run_period[i] = speed_to_period(held_speed[i]);
                cyc        = 1;
                m          = 0;
                next_phase = 0;
            end
            // Walk the schedule until a motor fires or the frame runs out.
            while (cyc <= CYCLES_PER_FRAME_DEF) begin
                if (m >= MOTOR_COUNT_DEF) begin
                    cyc++;
                    m          = 0;
                    next_phase = 0;
                end else if (run_period[m] == 0) begin
                    set_coils(m, NO_HOT);
                    m++;
                end else begin
                    per = run_period[m];
                    mag = (per < 0) ? -per : per;
                    if (cyc % mag == 0) begin
                        hot = (per > 0) ? next_phase : 3 - next_phase;
                        set_coils(m, hot);
                        beat.motor = MOTOR_W'(m);
                        next_phase = (next_phase + 1) % 4;
                        if (next_phase == 0)
                            m++;
                        break;
                    end
                    m++;
                end
            end
            if (cyc > CYCLES_PER_FRAME_DEF) begin
                frame_cycle = 0;
                next_motor  = 0;
                next_phase  = 0;
            end else begin
                frame_cycle = cyc;
                next_motor  = m;
            end
        end
        beat.pins = coil_state;
        return beat;
    endfunction

    // Random speed command: many stopped motors, some out of range, most in range.
    function automatic logic [SPEED_W-1:0] rand_speed();
        int v;
        v = int'($urandom_range(0, 200)) - 100;
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return SPEED_W'($urandom_range(0, 255));
            4:       return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
            default: return v[SPEED_W-1:0];
        endcase
    endfunction

    // Sender pacing: bursts of random length, separated by random gaps or none.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offer one beat from a falling edge and record its expected result once taken.
    task automatic drive_beat(
        input logic                 cmd,
        input logic [IN_DATA_W-1:0] speeds,
        input logic                 given,
        input t_coil_beat           typed_beat
    );
        t_coil_beat predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= speeds;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        predicted = next_pin_beat(cmd, speeds);
        due_beats.push_back(given ? typed_beat : predicted);
        @(negedge i_clk);
    endtask

    // Hold the input quiet until every expected beat has come back.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        wait (due_beats.size() == 0);
        @(negedge i_clk);
    endtask

    // Stimulus: reset, directed table, then random loads and ticks.
    initial begin
        logic [IN_DATA_W-1:0] speeds;
        logic                 cmd;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            pace_sender();
            drive_beat(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].speeds, DIRECTED_ROWS[r].given,
                       '{motor: DIRECTED_ROWS[r].motor, pins: DIRECTED_ROWS[r].pins});
        end
        drain_outputs();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Receiver holds off for a long stretch while items keep coming.
            if (n == HOLD_OFF_ITEM)
                hold_req = 1'b1;
            if (n == DRAIN_ITEM)
                drain_outputs();
            pace_sender();
            cmd = ($urandom_range(0, 24) == 0) ? CMD_LOAD : CMD_TICK;
            speeds = IN_DATA_W'({$urandom, $urandom});
            if (cmd == CMD_LOAD) begin
                if ($urandom_range(0, 7) == 0)
                    speeds = '0;
                else
                    for (int j = 0; j < MOTOR_SLOTS; j++)
                        speeds[SPEED_W*j +: SPEED_W] = rand_speed();
            end
            drive_beat(cmd, speeds, 1'b0, '0);
        end

        // Let the last beats out and watch for stray ones.
        s_tvalid <= 1'b0;
        wait (due_beats.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_six_stepper_wave_drive_sequencer: clean");
        else
            $display("tb_six_stepper_wave_drive_sequencer: errors");
        $finish;
    end

    // Receiver: switches among random stall patterns, with one long hold-off.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF_LEN; k++)
                    @(negedge i_clk);
            end else begin
                rx_count++;
                if (rx_count % 96 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_count % 3 == 0);
                endcase
            end
        end
    end

    // Compare each output beat with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches < 100)
                    $display("%0t ns: unexpected beat, expected none, got %h", $time, m_tdata);
            end else begin
                oldest_due = due_beats.pop_front();
                if (m_tdata[PINS_W-1:0] !== oldest_due.pins) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t ns: coil_pins expected %h got %h",
                                 $time, oldest_due.pins, m_tdata[PINS_W-1:0]);
                end
                if (m_tdata[PINS_W +: MOTOR_W] !== oldest_due.motor) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t ns: active_motor expected %0d got %0d",
                                 $time, oldest_due.motor, m_tdata[PINS_W +: MOTOR_W]);
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #16_000_000;
        $display("tb_six_stepper_wave_drive_sequencer: errors");
        $finish;
    end

endmodule
